FILE: design/hmmd_pkg.sv
package hmmd_pkg;

   localparam int WORK_RAM_DEPTH_DEFAULT = 8192;
   localparam int HIGH_RAM_DEPTH_DEFAULT = 128;
   localparam int BOOT_ROM_DEPTH         = 256;
   localparam int BOOT_INDEX_WIDTH       = $clog2(BOOT_ROM_DEPTH);

   // request kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DMA   = 2'd2;

   // routing targets
   localparam logic [2:0] TGT_INSIDE   = 3'd0;
   localparam logic [2:0] TGT_ROM      = 3'd1;
   localparam logic [2:0] TGT_VRAM     = 3'd2;
   localparam logic [2:0] TGT_ERAM     = 3'd3;
   localparam logic [2:0] TGT_OAM      = 3'd4;
   localparam logic [2:0] TGT_JOYPAD   = 3'd5;
   localparam logic [2:0] TGT_VIDREG   = 3'd6;
   localparam logic [2:0] TGT_UNMAPPED = 3'd7;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CART_PRESENT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXT_RAM_PRESENT = 2'd1;

   // address map
   localparam logic [15:0] BOOT_END    = 16'h0100;
   localparam logic [15:0] OVERLAY_END = 16'h1000;
   localparam logic [15:0] ROM_END     = 16'h8000;
   localparam logic [15:0] VRAM_END    = 16'hA000;
   localparam logic [15:0] ERAM_END    = 16'hC000;
   localparam logic [15:0] OAM_BASE    = 16'hFE00;
   localparam logic [15:0] OAM_END     = 16'hFEA0;
   localparam logic [15:0] IO_BASE     = 16'hFF00;
   localparam logic [15:0] WRAM_MASK   = 16'h1FFF;
   localparam logic [15:0] HRAM_MASK   = 16'h007F;

   // low byte of the I/O page
   localparam logic [7:0] IO_JOYPAD    = 8'h00;
   localparam logic [7:0] IO_IRQ_FLAGS = 8'h0F;
   localparam logic [7:0] IO_VID_FIRST = 8'h40;
   localparam logic [7:0] IO_VID_LAST  = 8'h4B;
   localparam logic [7:0] IO_DMA       = 8'h46;
   localparam logic [7:0] IO_BOOT      = 8'h50;
   localparam logic [7:0] IO_HRAM      = 8'h80;
   localparam logic [7:0] IO_IRQ_EN    = 8'hFF;

   localparam logic [7:0] DMA_PAGE_MAX  = 8'hF1;
   localparam logic [7:0] DMA_COUNT_MAX = 8'h9F;
   localparam logic [7:0] DMA_IDLE_PAGE = 8'hFF;
   localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

   localparam logic [7:0] BOOT_IMAGE [BOOT_ROM_DEPTH] = '{
      8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
      8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
      8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
      8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
      8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
      8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
      8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
      8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
      8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hE2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
      8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
      8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
      8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
      8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
      8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h3C,
      8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
      8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
   };

   // where the read byte of a result comes from
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_WRAM,
      SRC_HRAM
   } hmmd_src_type;

   typedef struct packed {
      logic [2:0]   target;
      logic [14:0]  offset;
      logic [7:0]   read_data;
      logic         dma_valid;
      logic [15:0]  dma_source;
      logic [7:0]   dma_index;
      hmmd_src_type src;
   } hmmd_result_type;

   typedef struct packed {
      logic        wram_sel;
      logic        hram_sel;
      logic        write;
      logic [12:0] wram_addr;
      logic [6:0]  hram_addr;
      logic [7:0]  data;
   } hmmd_mem_req_type;

endpackage

FILE: design/handheld_memory_map_decoder.sv
// Response path: an accepted request is registered in the stage, then in the response
// registers, which hold it until rsp_ready takes it.
// Throughput: one request per cycle while responses are taken and no clear runs; the RAM read
// issued at accept time is the only memory access; its registered data feeds the following stage.
// Reset: control registers take their reset values at once; then a pass zeroes one work RAM
// entry per cycle (high RAM alongside) over all WORK_RAM_DEPTH entries, during which no request is taken.
module handheld_memory_map_decoder #(
   parameter int WORK_RAM_DEPTH = hmmd_pkg::WORK_RAM_DEPTH_DEFAULT,
   parameter int HIGH_RAM_DEPTH = hmmd_pkg::HIGH_RAM_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hmmd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic                                 csr_write_data,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic [15:0]                          req_address,
   input  logic [7:0]                           req_write_data,
   input  logic [15:0]                          req_cpu_pc,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_target,
   output logic [14:0]                          rsp_offset,
   output logic [7:0]                           rsp_read_data,
   output logic                                 rsp_dma_valid,
   output logic [15:0]                          rsp_dma_source,
   output logic [7:0]                           rsp_dma_index
);

   logic cart_present_ff, cart_present_in;
   logic ext_ram_present_ff, ext_ram_present_in;

   logic                      stage_valid_ff, stage_valid_in;
   hmmd_pkg::hmmd_result_type stage_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_target_ff;
   logic [14:0]               rsp_offset_ff;
   logic [7:0]                rsp_read_data_ff, rsp_read_data_in;
   logic                      rsp_dma_valid_ff;
   logic [15:0]               rsp_dma_source_ff;
   logic [7:0]                rsp_dma_index_ff;

   hmmd_pkg::hmmd_result_type  dec_result;
   hmmd_pkg::hmmd_mem_req_type mem_req;
   logic                       clearing;
   logic [7:0]                 wram_rdata;
   logic [7:0]                 hram_rdata;
   logic                       req_fire;
   logic                       stage_advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cart_present_in    = cart_present_ff;
      ext_ram_present_in = ext_ram_present_ff;
      if (csr_valid) begin
         case (csr_index)
            hmmd_pkg::CSR_CART_PRESENT:    cart_present_in    = csr_write_data;
            hmmd_pkg::CSR_EXT_RAM_PRESENT: ext_ram_present_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_present_ff    <= 1'b0;
         ext_ram_present_ff <= 1'b0;
      end else begin
         cart_present_ff    <= cart_present_in;
         ext_ram_present_ff <= ext_ram_present_in;
      end
   end

   hmmd_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .fire            (req_fire),
      .cart_present    (cart_present_ff),
      .ext_ram_present (ext_ram_present_ff),
      .kind            (req_kind),
      .address         (req_address),
      .write_data      (req_write_data),
      .cpu_pc          (req_cpu_pc),
      .result          (dec_result),
      .mem_req         (mem_req)
   );

   hmmd_ram #(
      .WORK_RAM_DEPTH (WORK_RAM_DEPTH),
      .HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
   ) u_ram (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .mem_req    (mem_req),
      .clearing   (clearing),
      .wram_rdata (wram_rdata),
      .hram_rdata (hram_rdata)
   );

   // stage holds a request while its RAM read completes; RAM data stays put
   // until the next accept, which only happens when the stage moves on
   assign stage_advance = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready     = !clearing && (!stage_valid_ff || stage_advance);
   assign req_fire      = req_valid && req_ready;

   always_comb begin
      stage_valid_in = req_fire || (stage_valid_ff && !stage_advance);
      rsp_valid_in   = stage_advance || (rsp_valid_ff && !rsp_ready);
      case (stage_ff.src)
         hmmd_pkg::SRC_WRAM: rsp_read_data_in = wram_rdata;
         hmmd_pkg::SRC_HRAM: rsp_read_data_in = hram_rdata;
         default:            rsp_read_data_in = stage_ff.read_data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff <= dec_result;
      end
      if (stage_advance) begin
         rsp_target_ff     <= stage_ff.target;
         rsp_offset_ff     <= stage_ff.offset;
         rsp_read_data_ff  <= rsp_read_data_in;
         rsp_dma_valid_ff  <= stage_ff.dma_valid;
         rsp_dma_source_ff <= stage_ff.dma_source;
         rsp_dma_index_ff  <= stage_ff.dma_index;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_target     = rsp_target_ff;
   assign rsp_offset     = rsp_offset_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_dma_valid  = rsp_dma_valid_ff;
   assign rsp_dma_source = rsp_dma_source_ff;
   assign rsp_dma_index  = rsp_dma_index_ff;

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_fire)
      else $error("request accepted during RAM clear");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> stage_valid_ff)
      else $error("accepted request lost before stage");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_valid_ff))
      else $error("response appeared without a staged request");

   a_dma_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dma_valid_ff) |->
         (rsp_target_ff == hmmd_pkg::TGT_INSIDE &&
          rsp_dma_index_ff <= hmmd_pkg::DMA_COUNT_MAX))
      else $error("DMA copy request with bad target or index");
`endif

endmodule

FILE: design/hmmd_ram.sv
module hmmd_ram #(
   parameter int WORK_RAM_DEPTH = hmmd_pkg::WORK_RAM_DEPTH_DEFAULT,
   parameter int HIGH_RAM_DEPTH = hmmd_pkg::HIGH_RAM_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  hmmd_pkg::hmmd_mem_req_type mem_req,
   output logic                       clearing,
   output logic [7:0]                 wram_rdata,
   output logic [7:0]                 hram_rdata
);

   localparam int WA = $clog2(WORK_RAM_DEPTH);
   localparam int HA = $clog2(HIGH_RAM_DEPTH);
   localparam logic [17:0] WD = 18'(WORK_RAM_DEPTH);
   localparam logic [7:0]  HD = 8'(HIGH_RAM_DEPTH);

   logic [7:0] wram [WORK_RAM_DEPTH];
   logic [7:0] hram [HIGH_RAM_DEPTH];

   logic          clear_active_ff, clear_active_in;
   logic [WA-1:0] clear_cnt_ff, clear_cnt_in;
   logic [7:0]    wram_rdata_ff;
   logic [7:0]    hram_rdata_ff;
   logic [WA-1:0] wram_idx;
   logic [HA-1:0] hram_idx;
   logic          hram_clear;

   // 13-bit address mod depth; quotient is below 8, so three restoring steps
   function automatic logic [WA-1:0] wram_index(logic [12:0] v);
      logic [17:0] r;
      r = {5'b0, v};
      for (int k = 2; k >= 0; k--) begin
         if (r >= (WD << k)) begin
            r = r - (WD << k);
         end
      end
      return r[WA-1:0];
   endfunction

   function automatic logic [HA-1:0] hram_index(logic [6:0] v);
      logic [7:0] r;
      r = {1'b0, v};
      if (r >= HD) begin
         r = r - HD;
      end
      return r[HA-1:0];
   endfunction

   assign wram_idx   = wram_index(mem_req.wram_addr);
   assign hram_idx   = hram_index(mem_req.hram_addr);
   assign hram_clear = clear_cnt_ff < WA'(HIGH_RAM_DEPTH);

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_cnt_in    = clear_cnt_ff;
      if (clear_active_ff) begin
         clear_cnt_in = clear_cnt_ff + WA'(1);
         if (clear_cnt_ff == WA'(WORK_RAM_DEPTH - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_cnt_ff    <= '0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_cnt_ff    <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_active_ff) begin
         wram[clear_cnt_ff] <= 8'h00;
      end else if (fire && mem_req.wram_sel) begin
         if (mem_req.write) begin
            wram[wram_idx] <= mem_req.data;
         end else begin
            wram_rdata_ff <= wram[wram_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_active_ff) begin
         if (hram_clear) begin
            hram[clear_cnt_ff[HA-1:0]] <= 8'h00;
         end
      end else if (fire && mem_req.hram_sel) begin
         if (mem_req.write) begin
            hram[hram_idx] <= mem_req.data;
         end else begin
            hram_rdata_ff <= hram[hram_idx];
         end
      end
   end

   assign clearing   = clear_active_ff;
   assign wram_rdata = wram_rdata_ff;
   assign hram_rdata = hram_rdata_ff;

endmodule

FILE: design/hmmd_decode.sv
module hmmd_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic                       cart_present,
   input  logic                       ext_ram_present,
   input  logic [1:0]                 kind,
   input  logic [15:0]                address,
   input  logic [7:0]                 write_data,
   input  logic [15:0]                cpu_pc,
   output hmmd_pkg::hmmd_result_type  result,
   output hmmd_pkg::hmmd_mem_req_type mem_req
);

   logic       boot_overlay_ff, boot_overlay_in;
   logic [7:0] irq_flags_ff, irq_flags_in;
   logic [7:0] irq_enables_ff, irq_enables_in;
   logic [7:0] dma_page_ff, dma_page_in;
   logic [7:0] dma_count_ff, dma_count_in;

   always_comb begin
      logic       wr;
      logic [7:0] lo;
      wr = (kind == hmmd_pkg::KIND_WRITE);
      lo = address[7:0];

      result           = '0;
      result.target    = hmmd_pkg::TGT_INSIDE;
      result.src       = hmmd_pkg::SRC_NONE;
      mem_req          = '0;
      mem_req.write    = wr;
      mem_req.wram_addr = 13'(address & hmmd_pkg::WRAM_MASK);
      mem_req.hram_addr = 7'(address & hmmd_pkg::HRAM_MASK);
      mem_req.data     = write_data;

      boot_overlay_in = boot_overlay_ff;
      irq_flags_in    = irq_flags_ff;
      irq_enables_in  = irq_enables_ff;
      dma_page_in     = dma_page_ff;
      dma_count_in    = dma_count_ff;

      if (kind == hmmd_pkg::KIND_READ || kind == hmmd_pkg::KIND_WRITE) begin
         result.target    = hmmd_pkg::TGT_UNMAPPED;
         result.read_data = wr ? 8'h00 : hmmd_pkg::UNMAPPED_BYTE;
         if (address < hmmd_pkg::ROM_END) begin
            if (!wr) begin
               if (address < hmmd_pkg::BOOT_END && boot_overlay_ff) begin
                  result.target    = hmmd_pkg::TGT_INSIDE;
                  result.read_data =
                     hmmd_pkg::BOOT_IMAGE[address[hmmd_pkg::BOOT_INDEX_WIDTH-1:0]];
               end else begin
                  // first fetch past the boot program ends the overlay
                  if (address < hmmd_pkg::OVERLAY_END && boot_overlay_ff &&
                      cpu_pc == hmmd_pkg::BOOT_END) begin
                     boot_overlay_in = 1'b0;
                  end
                  if (cart_present) begin
                     result.target    = hmmd_pkg::TGT_ROM;
                     result.offset    = address[14:0];
                     result.read_data = 8'h00;
                  end
               end
            end
         end else if (address < hmmd_pkg::VRAM_END) begin
            result.target    = hmmd_pkg::TGT_VRAM;
            result.offset    = 15'(address & hmmd_pkg::WRAM_MASK);
            result.read_data = 8'h00;
         end else if (address < hmmd_pkg::ERAM_END) begin
            if (ext_ram_present) begin
               result.target    = hmmd_pkg::TGT_ERAM;
               result.offset    = 15'(address & hmmd_pkg::WRAM_MASK);
               result.read_data = 8'h00;
            end
         end else if (address < hmmd_pkg::OAM_BASE) begin
            // work RAM and its echo
            result.target    = hmmd_pkg::TGT_INSIDE;
            result.read_data = 8'h00;
            mem_req.wram_sel = 1'b1;
            if (!wr) begin
               result.src = hmmd_pkg::SRC_WRAM;
            end
         end else if (address < hmmd_pkg::OAM_END) begin
            result.target    = hmmd_pkg::TGT_OAM;
            result.offset    = 15'(address - hmmd_pkg::OAM_BASE);
            result.read_data = 8'h00;
         end else if (address >= hmmd_pkg::IO_BASE) begin
            if (lo == hmmd_pkg::IO_JOYPAD) begin
               result.target    = hmmd_pkg::TGT_JOYPAD;
               result.read_data = 8'h00;
            end else if (lo == hmmd_pkg::IO_IRQ_FLAGS) begin
               result.target = hmmd_pkg::TGT_INSIDE;
               if (wr) begin
                  irq_flags_in = write_data;
               end else begin
                  result.read_data = irq_flags_ff;
               end
            end else if (lo >= hmmd_pkg::IO_VID_FIRST && lo <= hmmd_pkg::IO_VID_LAST) begin
               if (lo == hmmd_pkg::IO_DMA) begin
                  if (wr) begin
                     result.target = hmmd_pkg::TGT_INSIDE;
                     dma_page_in   = write_data;
                     dma_count_in  = 8'h00;
                  end
               end else begin
                  result.target    = hmmd_pkg::TGT_VIDREG;
                  result.offset    = 15'(lo - hmmd_pkg::IO_VID_FIRST);
                  result.read_data = 8'h00;
               end
            end else if (lo == hmmd_pkg::IO_BOOT) begin
               result.target = hmmd_pkg::TGT_INSIDE;
               if (wr) begin
                  if (write_data != 8'h00) begin
                     boot_overlay_in = 1'b0;
                  end
               end else begin
                  result.read_data = {7'b0, ~boot_overlay_ff};
               end
            end else if (lo == hmmd_pkg::IO_IRQ_EN) begin
               result.target = hmmd_pkg::TGT_INSIDE;
               if (wr) begin
                  irq_enables_in = write_data;
               end else begin
                  result.read_data = irq_enables_ff;
               end
            end else if (lo >= hmmd_pkg::IO_HRAM) begin
               result.target    = hmmd_pkg::TGT_INSIDE;
               result.read_data = 8'h00;
               mem_req.hram_sel = 1'b1;
               if (!wr) begin
                  result.src = hmmd_pkg::SRC_HRAM;
               end
            end
         end
      end else if (kind == hmmd_pkg::KIND_DMA) begin
         if (dma_page_ff <= hmmd_pkg::DMA_PAGE_MAX &&
             dma_count_ff <= hmmd_pkg::DMA_COUNT_MAX) begin
            result.dma_valid  = 1'b1;
            result.dma_source = {dma_page_ff, dma_count_ff};
            result.dma_index  = dma_count_ff;
            dma_count_in      = dma_count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_overlay_ff <= 1'b1;
         irq_flags_ff    <= 8'h00;
         irq_enables_ff  <= 8'h00;
         dma_page_ff     <= hmmd_pkg::DMA_IDLE_PAGE;
         dma_count_ff    <= 8'h00;
      end else if (fire) begin
         boot_overlay_ff <= boot_overlay_in;
         irq_flags_ff    <= irq_flags_in;
         irq_enables_ff  <= irq_enables_in;
         dma_page_ff     <= dma_page_in;
         dma_count_ff    <= dma_count_in;
      end
   end

endmodule
